>>> design/swm_pkg.sv
// swm_pkg: shared types for the sliding-window maximum block.
// Holds the transaction payload structs and the controller/datapath link.
// No dependencies.
`default_nettype none

package swm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int POS_W    = 16;
  localparam int WSIZE_W  = 7;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start_of_stream;
  } swm_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] window_max;
    logic        [POS_W-1:0]    window_start;
  } swm_out_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic drop_head;
    logic drop_tail;
    logic push;
  } swm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic front_stale;  // head entry has left the window
    logic back_le;      // tail entry not larger than the new sample
    logic item_vld;     // current sample produces a result
    logic out_free;     // output register can take a result this cycle
  } swm_sts_t;

endpackage

`default_nettype wire

>>> design/swm_ctrl.sv
// swm_ctrl: sequencing of one sample through the deque.
// Depends on swm_pkg.
`default_nettype none

module swm_ctrl import swm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire swm_sts_t sts,
  output swm_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHK,
    ST_WAIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_CHK;
        end
      end
      ST_CHK: begin
        if (sts.front_stale) begin
          cmd.drop_head = 1'b1;
          state_nxt     = ST_WAIT;
        end else if (sts.back_le) begin
          cmd.drop_tail = 1'b1;
          state_nxt     = ST_WAIT;
        end else if (!sts.item_vld || sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_WAIT: begin
        // read registers pick up the moved head/tail
        state_nxt = ST_CHK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/swm_dpath.sv
// swm_dpath: deque storage, pointers, position counter, window register, result register.
// Depends on swm_pkg.
`default_nettype none

module swm_dpath import swm_pkg::*; #(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire swm_in_t             in_data,
  input  wire logic                cfg_we,
  input  wire logic [WSIZE_W-1:0]  cfg_data,
  input  wire swm_cmd_t            cmd,
  output swm_sts_t                 sts,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output swm_out_t                 out_data
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_WINDOW - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_WINDOW);

  logic [WSIZE_W-1:0] wsize_r;
  logic [AW-1:0]      head_r, tail_r;
  logic [CW-1:0]      count_r;
  logic [POS_W-1:0]   spos_r;
  logic               filled_r;

  logic signed [SAMPLE_W-1:0] cur_val_r;
  logic [POS_W-1:0]           cur_pos_r;
  logic                       item_vld_r;

  logic signed [SAMPLE_W-1:0] mem_val [MAX_WINDOW];
  logic [POS_W-1:0]           mem_pos [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] rd_head_val_r, rd_tail_val_r;
  logic [POS_W-1:0]           rd_head_pos_r;

  logic     out_valid_r;
  swm_out_t out_data_r;

  logic [31:0]        wsat;
  logic [POS_W-1:0]   wm1;
  logic [AW-1:0]      tail_prev, tail_next, head_next;
  logic [POS_W-1:0]   age;
  logic               guard;
  logic [POS_W-1:0]   acc_pos;
  logic               acc_filled;

  // effective window: zero acts as one, clamp at deque depth
  always_comb begin
    if (wsize_r == '0) begin
      wsat = 32'd1;
    end else if (32'(wsize_r) > 32'(MAX_WINDOW)) begin
      wsat = 32'(MAX_WINDOW);
    end else begin
      wsat = 32'(wsize_r);
    end
    wm1 = POS_W'(wsat - 32'd1);
  end

  assign tail_prev = (tail_r == '0) ? LAST_SLOT : tail_r - AW'(1);
  assign tail_next = (tail_r == LAST_SLOT) ? '0 : tail_r + AW'(1);
  assign head_next = (head_r == LAST_SLOT) ? '0 : head_r + AW'(1);
  assign age       = cur_pos_r - rd_head_pos_r;
  assign guard     = (count_r >= FULL_CNT);

  assign acc_pos    = in_data.start_of_stream ? '0 : spos_r;
  assign acc_filled = in_data.start_of_stream ? 1'b0 : filled_r;

  assign sts.front_stale = (count_r != '0) && (age > wm1);
  assign sts.back_le     = (count_r != '0) && (rd_tail_val_r <= cur_val_r);
  assign sts.item_vld    = item_vld_r;
  assign sts.out_free    = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r <= WSIZE_W'(3);
    end else if (cfg_we) begin
      wsize_r <= cfg_data;
    end
  end

  // pointers, counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      spos_r   <= '0;
      filled_r <= 1'b0;
    end else if (cmd.accept) begin
      if (in_data.start_of_stream) begin
        head_r  <= '0;
        tail_r  <= '0;
        count_r <= '0;
      end
      spos_r   <= acc_pos + POS_W'(1);
      filled_r <= acc_filled || (acc_pos == '1);
    end else if (cmd.drop_head) begin
      head_r  <= head_next;
      count_r <= count_r - CW'(1);
    end else if (cmd.drop_tail) begin
      tail_r  <= tail_prev;
      count_r <= count_r - CW'(1);
    end else if (cmd.push) begin
      tail_r <= tail_next;
      if (guard) begin
        head_r <= head_next;
      end else begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  // current sample
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_val_r  <= in_data.sample;
      cur_pos_r  <= acc_pos;
      item_vld_r <= acc_filled || (acc_pos >= wm1);
    end
  end

  // deque storage, one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem_val[tail_r] <= cur_val_r;
      mem_pos[tail_r] <= cur_pos_r;
    end
    rd_head_val_r <= mem_val[head_r];
    rd_head_pos_r <= mem_pos[head_r];
    rd_tail_val_r <= mem_val[tail_prev];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push && item_vld_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && item_vld_r) begin
      out_data_r.window_max   <= (count_r == '0) ? cur_val_r : rd_head_val_r;
      out_data_r.window_start <= cur_pos_r - wm1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> design/sliding_window_maximum_core.sv
// sliding_window_maximum_core: running maximum over the last window_size samples.
// Sequence: an accepted sample goes to CHK, each deque pop passes through WAIT back to CHK,
//   and the push from CHK registers any result into out_valid; in_stall is high until then, so
//   a new sample is taken only after the last one is pushed, and a push with a result waits on out_stall.
// Reset (rst_n, synchronous): empty deque, position 0, window_size 3. No memory clear.
// Depends on swm_pkg, swm_ctrl, swm_dpath.
`default_nettype none

module sliding_window_maximum_core import swm_pkg::*; #(
  parameter int MAX_WINDOW = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // sample transactions
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire swm_in_t            in_data,
  // result transactions
  output logic                    out_valid,
  input  wire logic               out_stall,
  output swm_out_t                out_data,
  // window_size register write
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [WSIZE_W-1:0] cfg_data
);

  swm_cmd_t cmd;
  swm_sts_t sts;

  // Register writes must only be issued while idle (not enforced here); they are always taken.
  assign cfg_ready = 1'b1;

  // Controller: IDLE takes a sample; CHK drops a stale head, else pops a
  // tail entry not larger than the sample, else pushes (emitting a result if the sample completes a window).
  // Every pop passes through WAIT so the registered memory reads catch up.
  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: deque memories (value, position), head/tail/count, position
  // counter with wrap flag, and a result register that frees the input side.
  swm_dpath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> tb/sliding_window_maximum_core_tb.sv
// Self-checking testbench for sliding_window_maximum_core: directed table, then random phases.
// An in-bench deque predictor supplies the expected window maxima and window start positions.
// Depends on swm_pkg and the sliding_window_maximum_core RTL.
module sliding_window_maximum_core_tb import swm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 8;
  localparam int RESET_CYCLES    = 5;
  localparam int MAX_WINDOW      = 64;
  // Margin for the longest deque walk to finish before touching the register.
  localparam int DRAIN_CYCLES    = 200;
  localparam int HOLD_OFF_CYCLES = 400;
  // Watchdog limit; a normal run ends well before it, even with every item doing its worst walk.
  localparam int CYCLE_LIMIT     = 2_000_000;

  localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;

  // Directed rows: a sample with a typed outcome, a sample left to the predictor,
  // or a window_size write (value carried in the low bits of the sample field).
  typedef enum logic [1:0] {
    ROW_NO_RESULT,
    ROW_RESULT,
    ROW_PREDICT,
    ROW_WINDOW
  } row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic signed [SAMPLE_W-1:0] value;
    logic                       sos;
    logic signed [SAMPLE_W-1:0] exp_max;
    logic [POS_W-1:0]           exp_start;
  } stim_row_t;

  localparam int DIR_ROWS = 24;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // reset window of 3: first two samples of a stream give nothing
    '{ROW_NO_RESULT, S_MIN,   1'b1, 32'sd0,  16'd0},
    '{ROW_NO_RESULT, S_MAX,   1'b0, 32'sd0,  16'd0},
    '{ROW_RESULT,    32'sd0,  1'b0, S_MAX,   16'd0},
    '{ROW_RESULT,    -32'sd1, 1'b0, S_MAX,   16'd1},
    // the maximum slides out of the front
    '{ROW_RESULT,    -32'sd1, 1'b0, 32'sd0,  16'd2},
    '{ROW_RESULT,    32'sd5,  1'b0, 32'sd5,  16'd3},
    // equal sample replaces the older entry
    '{ROW_RESULT,    32'sd5,  1'b0, 32'sd5,  16'd4},
    // restart the stream mid-way
    '{ROW_NO_RESULT, 32'sd7,  1'b1, 32'sd0,  16'd0},
    '{ROW_NO_RESULT, S_MIN,   1'b0, 32'sd0,  16'd0},
    '{ROW_RESULT,    S_MIN,   1'b0, 32'sd7,  16'd0},
    '{ROW_RESULT,    S_MIN,   1'b0, S_MIN,   16'd1},
    '{ROW_RESULT,    S_MAX,   1'b0, S_MAX,   16'd2},
    // size zero acts as 1, shrinking mid-stream
    '{ROW_WINDOW,    32'sd0,  1'b0, 32'sd0,  16'd0},
    '{ROW_RESULT,    -32'sd9, 1'b0, -32'sd9, 16'd5},
    '{ROW_RESULT,    32'sd100, 1'b0, 32'sd100, 16'd6},
    // oversize saturates to 64: growing mid-stream withholds results again
    '{ROW_WINDOW,    32'sd127, 1'b0, 32'sd0, 16'd0},
    '{ROW_NO_RESULT, 32'sd1,  1'b0, 32'sd0,  16'd0},
    '{ROW_NO_RESULT, 32'sd2,  1'b1, 32'sd0,  16'd0},
    '{ROW_WINDOW,    32'sd1,  1'b0, 32'sd0,  16'd0},
    '{ROW_RESULT,    32'sd3,  1'b0, 32'sd3,  16'd1},
    '{ROW_WINDOW,    32'sd2,  1'b0, 32'sd0,  16'd0},
    '{ROW_NO_RESULT, S_MAX,   1'b1, 32'sd0,  16'd0},
    '{ROW_PREDICT,   S_MIN,   1'b0, 32'sd0,  16'd0},
    '{ROW_PREDICT,   -32'sd5, 1'b0, 32'sd0,  16'd0}
  };

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  swm_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  swm_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [WSIZE_W-1:0]   cfg_data  = '0;

  sliding_window_maximum_core #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Traffic shaping, set per phase by the main sequence.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_off      = 1'b0;

  int mismatches = 0;
  int cycle_count = 0;

  swm_out_t expected_maxima[$];

  // ---------------------------------------------------------------------------
  // Window-maximum predictor: a monotonic deque of (value, position) candidates,
  // values strictly decreasing from front to back. Own copy of window_size.
  // ---------------------------------------------------------------------------
  logic [WSIZE_W-1:0]         model_wsize   = 7'd3;
  logic signed [SAMPLE_W-1:0] cand_value[$];
  logic [POS_W-1:0]           cand_pos[$];
  logic [POS_W-1:0]           next_position = '0;
  bit                         wrapped_once  = 1'b0;
  logic signed [SAMPLE_W-1:0] walk_value    = '0;

  function automatic bit advance_window(input swm_in_t s, output swm_out_t r);
    int               w;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] age;
    bit               has;
    w = int'(model_wsize);
    if (w == 0) w = 1;
    if (w > MAX_WINDOW) w = MAX_WINDOW;

    if (s.start_of_stream) begin
      cand_value.delete();
      cand_pos.delete();
      next_position = '0;
      wrapped_once  = 1'b0;
    end
    pos = next_position;

    // retire candidates older than the window; ages taken mod 2^16
    while (cand_pos.size() > 0) begin
      age = pos - cand_pos[0];
      if (int'(age) <= w - 1) break;
      cand_value.delete(0);
      cand_pos.delete(0);
    end

    // anything not larger than the newcomer can never be the maximum again
    while (cand_value.size() > 0 && cand_value[$] <= s.sample) begin
      cand_value.delete(cand_value.size() - 1);
      cand_pos.delete(cand_pos.size() - 1);
    end

    // guard only, unreachable with a legal window
    if (cand_value.size() >= MAX_WINDOW) begin
      cand_value.delete(0);
      cand_pos.delete(0);
    end
    cand_value = {cand_value, s.sample};
    cand_pos   = {cand_pos, pos};

    has = wrapped_once || (int'(pos) + 1 >= w);
    if (pos == '1) wrapped_once = 1'b1;
    next_position = pos + 1'b1;

    r.window_max   = cand_value[0];
    r.window_start = pos - POS_W'(w - 1);
    return has;
  endfunction

  // Mix of extremes, near-equal walks (lots of equal values and long pops) and noise.
  function automatic logic signed [SAMPLE_W-1:0] next_random_sample();
    case ($urandom_range(0, 9))
      0:       return S_MIN;
      1:       return S_MAX;
      2:       return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
      3, 4, 5: begin
        walk_value = walk_value + ($signed($urandom_range(0, 6)) - 3);
        return walk_value;
      end
      6:       return -$signed($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // Offer one sample transaction, with a random idle gap first; predict on acceptance.
  // Valid is left high afterwards so back-to-back transactions need no gap.
  task automatic send_sample(input swm_in_t s, output bit has, output swm_out_t r);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    has = advance_window(s, r);
  endtask

  // Register write only with the block idle: all results back, then the walk latency.
  task automatic program_window_size(input logic [WSIZE_W-1:0] v);
    in_valid <= 1'b0;
    while (expected_maxima.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    model_wsize = v;
  endtask

  // One random phase. No start flag at the head unless open_stream, so a new
  // window_size normally lands in the middle of a running stream.
  task automatic run_phase(input logic [WSIZE_W-1:0] wsize, input int idle_pct,
                           input int stall_chance, input int n, input int sos_pct,
                           input bit open_stream, input bit long_hold);
    swm_in_t  s;
    swm_out_t r;
    bit       has;
    int       i;
    program_window_size(wsize);
    send_idle_pct = idle_pct;
    stall_pct     = stall_chance;
    if (long_hold) hold_off = 1'b1;
    for (i = 0; i < n; i++) begin
      s.sample          = next_random_sample();
      s.start_of_stream = (open_stream && i == 0) || ($urandom_range(0, 99) < sos_pct);
      send_sample(s, has, r);
      if (has) expected_maxima = {expected_maxima, r};
    end
  endtask

  // Receiver: random stalls, plus one long counted hold-off so the deque walk
  // backs up and in_stall is exercised.
  initial begin : receiver
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_off && held < HOLD_OFF_CYCLES) begin
        out_stall <= 1'b1;
        held++;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Result checker: each accepted result transaction against the oldest expectation.
  always @(posedge clk) begin
    swm_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_maxima.size() == 0) begin
        report_mismatch("unexpected result, window_max", 0, out_data.window_max);
      end else begin
        want = expected_maxima[0];
        expected_maxima.delete(0);
        if (out_data.window_max !== want.window_max)
          report_mismatch("window_max", want.window_max, out_data.window_max);
        if (out_data.window_start !== want.window_start)
          report_mismatch("window_start", want.window_start, out_data.window_start);
      end
    end
  end

  // Watchdog.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Main sequence.
  initial begin : main_seq
    stim_row_t row;
    swm_in_t   s;
    swm_out_t  r;
    swm_out_t  exp_r;
    bit        has;
    int        i;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, starting under the reset window of 3, no idling.
    for (i = 0; i < DIR_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_WINDOW) begin
        program_window_size(row.value[WSIZE_W-1:0]);
      end else begin
        s.sample          = row.value;
        s.start_of_stream = row.sos;
        send_sample(s, has, r);
        case (row.kind)
          ROW_RESULT: begin
            exp_r.window_max   = row.exp_max;
            exp_r.window_start = row.exp_start;
            expected_maxima    = {expected_maxima, exp_r};
          end
          ROW_PREDICT: begin
            if (has) expected_maxima = {expected_maxima, r};
          end
          default: ;
        endcase
      end
    end

    // Random phases: window extremes and random sizes, each idling pattern.
    run_phase(7'd5,   0,  0,  220, 2, 1'b0, 1'b0);
    run_phase(7'd1,   47, 0,  180, 2, 1'b0, 1'b0);
    run_phase(7'd64,  0,  47, 220, 2, 1'b0, 1'b0);
    run_phase(7'd127, 13, 13, 180, 2, 1'b0, 1'b0);
    run_phase(7'd0,   0,  0,  150, 2, 1'b0, 1'b1);
    run_phase(WSIZE_W'($urandom_range(2, 20)),  47, 0,  220, 2, 1'b0, 1'b0);
    run_phase(WSIZE_W'($urandom_range(0, 127)), 13, 13, 200, 2, 1'b0, 1'b0);

    // Size changes mid-stream, then frequent restarts.
    run_phase(7'd2, 13, 13, 100, 0, 1'b0, 1'b0);
    run_phase(7'd9, 13, 13, 60,  5, 1'b0, 1'b0);

    in_valid <= 1'b0;
    while (expected_maxima.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
